### rtl/fdfr_pkg.sv
// Shared types and constants for the flag-delimited frame receiver.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fdfr_pkg;

    // Buffer pool geometry. The port widths below are fixed by the interface.
    localparam int NUM_BUFFERS = 4;
    localparam int IDX_W       = 2;
    localparam int OFF_W       = 11;
    localparam int COUNT_W     = 12;

    localparam logic [COUNT_W-1:0] BUFFER_BYTES = 12'd2048;
    localparam logic [7:0]         FLAG_BYTE    = 8'h7e;

    typedef enum logic [0:0] {
        CMD_BYTE    = 1'b0,
        CMD_RELEASE = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_RECEIVING = 2'd1,
        ST_READY     = 2'd2,
        ST_FULL      = 2'd3
    } t_buf_state;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STORED    = 3'd1,
        EV_READY     = 3'd2,
        EV_DROPPED   = 3'd3,
        EV_NO_BUFFER = 3'd4
    } t_event;

    // One result word.
    typedef struct packed {
        t_event             ev;
        logic               we;
        logic [IDX_W-1:0]   idx;
        logic [OFF_W-1:0]   off;
        logic [7:0]         wr_byte;
        logic [COUNT_W-1:0] len;
    } t_result;

    // Single write port into the buffer status table.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_buf_state       value;
    } t_stat_wr;

    // What the frame logic sees of the status table.
    typedef struct packed {
        logic             any_free;
        logic [IDX_W-1:0] free_idx;
        t_buf_state       cur_state;
    } t_stat_view;

endpackage

`default_nettype wire

### rtl/fdfr_status.sv
// Buffer status table with a lowest-free-buffer priority encoder.
// Depends on fdfr_pkg for the status encoding and the port structs.
`timescale 1ns / 1ps
`default_nettype none

module fdfr_status (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [fdfr_pkg::IDX_W-1:0]  i_rd_idx,
    input  wire  fdfr_pkg::t_stat_wr    i_wr,
    output fdfr_pkg::t_stat_view        o_view
);

    fdfr_pkg::t_buf_state r_status [fdfr_pkg::NUM_BUFFERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fdfr_pkg::NUM_BUFFERS; k++) begin
                r_status[k] <= fdfr_pkg::ST_FREE;
            end
        end else if (i_wr.en) begin
            r_status[i_wr.idx] <= i_wr.value;
        end
    end

    // Scan from the top down so the lowest free buffer wins.
    always_comb begin
        o_view.any_free  = 1'b0;
        o_view.free_idx  = '0;
        o_view.cur_state = r_status[i_rd_idx];
        for (int k = fdfr_pkg::NUM_BUFFERS - 1; k >= 0; k--) begin
            if (r_status[k] == fdfr_pkg::ST_FREE) begin
                o_view.any_free = 1'b1;
                o_view.free_idx = k[fdfr_pkg::IDX_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/fdfr_frame.sv
// Frame tracking: in-frame flag, current buffer, byte count and the result decode.
// Depends on fdfr_pkg; reads and updates the table held in fdfr_status.
`timescale 1ns / 1ps
`default_nettype none

module fdfr_frame (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_accept,
    input  wire                         i_command,
    input  wire  [7:0]                  i_data_byte,
    input  wire  [fdfr_pkg::IDX_W-1:0]  i_release_index,
    input  wire  fdfr_pkg::t_stat_view  i_view,
    output logic [fdfr_pkg::IDX_W-1:0]  o_cur_buf,
    output fdfr_pkg::t_stat_wr          o_wr,
    output fdfr_pkg::t_result           o_result
);

    logic                            r_in_frame, n_in_frame;
    logic [fdfr_pkg::IDX_W-1:0]      r_cur_buf,  n_cur_buf;
    logic [fdfr_pkg::COUNT_W-1:0]    r_count,    n_count;

    logic                            is_flag;
    logic                            frame_full;
    logic [fdfr_pkg::COUNT_W-1:0]    count_inc;

    assign is_flag    = (i_data_byte == fdfr_pkg::FLAG_BYTE);
    assign frame_full = (i_view.cur_state == fdfr_pkg::ST_FULL) ||
                        (r_count >= fdfr_pkg::BUFFER_BYTES);
    // The count saturates at the buffer size.
    assign count_inc  = (r_count < fdfr_pkg::BUFFER_BYTES) ?
                        (r_count + fdfr_pkg::COUNT_W'(1)) : r_count;
    assign o_cur_buf  = r_cur_buf;

    always_comb begin
        n_in_frame = r_in_frame;
        n_cur_buf  = r_cur_buf;
        n_count    = r_count;
        o_wr       = '{en: 1'b0, idx: '0, value: fdfr_pkg::ST_FREE};
        o_result   = '{ev: fdfr_pkg::EV_NONE, we: 1'b0, idx: '0, off: '0,
                       wr_byte: '0, len: '0};

        if (i_command == fdfr_pkg::CMD_RELEASE) begin
            if (int'(i_release_index) < fdfr_pkg::NUM_BUFFERS) begin
                o_wr = '{en: 1'b1, idx: i_release_index, value: fdfr_pkg::ST_FREE};
            end
        end else if (!r_in_frame) begin
            if (is_flag) begin
                if (!i_view.any_free) begin
                    o_result.ev = fdfr_pkg::EV_NO_BUFFER;
                end else begin
                    // Opening flag goes to offset zero of the claimed buffer.
                    n_in_frame       = 1'b1;
                    n_cur_buf        = i_view.free_idx;
                    n_count          = fdfr_pkg::COUNT_W'(1);
                    o_wr             = '{en: 1'b1, idx: i_view.free_idx,
                                         value: fdfr_pkg::ST_RECEIVING};
                    o_result.ev      = fdfr_pkg::EV_STORED;
                    o_result.we      = 1'b1;
                    o_result.idx     = i_view.free_idx;
                    o_result.wr_byte = i_data_byte;
                end
            end
        end else if (is_flag) begin
            // A second flag right after the opening one is an idle fill and is skipped.
            if (r_count != fdfr_pkg::COUNT_W'(1)) begin
                n_in_frame   = 1'b0;
                n_count      = '0;
                o_result.idx = r_cur_buf;
                if (!frame_full) begin
                    o_wr             = '{en: 1'b1, idx: r_cur_buf, value: fdfr_pkg::ST_READY};
                    o_result.ev      = fdfr_pkg::EV_READY;
                    o_result.we      = 1'b1;
                    o_result.off     = r_count[fdfr_pkg::OFF_W-1:0];
                    o_result.wr_byte = i_data_byte;
                    o_result.len     = r_count + fdfr_pkg::COUNT_W'(1);
                end else begin
                    o_wr        = '{en: 1'b1, idx: r_cur_buf, value: fdfr_pkg::ST_FREE};
                    o_result.ev = fdfr_pkg::EV_DROPPED;
                end
            end
        end else begin
            if (!frame_full) begin
                o_result.ev      = fdfr_pkg::EV_STORED;
                o_result.we      = 1'b1;
                o_result.idx     = r_cur_buf;
                o_result.off     = r_count[fdfr_pkg::OFF_W-1:0];
                o_result.wr_byte = i_data_byte;
            end
            n_count = count_inc;
            if (count_inc >= fdfr_pkg::BUFFER_BYTES) begin
                o_wr = '{en: 1'b1, idx: r_cur_buf, value: fdfr_pkg::ST_FULL};
            end
        end

        // Nothing changes unless a word is actually taken.
        if (!i_accept) begin
            n_in_frame = r_in_frame;
            n_cur_buf  = r_cur_buf;
            n_count    = r_count;
            o_wr.en    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_cur_buf  <= '0;
            r_count    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_cur_buf  <= n_cur_buf;
            r_count    <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/fdfr_out_reg.sv
// Result register: holds one result word until the downstream side takes it.
// Depends on fdfr_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module fdfr_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire fdfr_pkg::t_result i_result,
    input  wire                 i_out_stall,
    output logic                o_valid,
    output fdfr_pkg::t_result   o_result
);

    logic               r_valid, n_valid;
    fdfr_pkg::t_result  r_result;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### rtl/flag_delimited_frame_receiver.sv
// Top level of the flag-delimited frame receiver.
// Depends on fdfr_pkg, fdfr_status, fdfr_frame and fdfr_out_reg.
//
//   Channel  Direction  Handshake                 Word
//   input    in         i_in_valid / o_in_stall   i_command, i_data_byte, i_release_index
//   output   out        o_out_valid / i_out_stall o_event_res, o_write_enable, o_buffer_index,
//                                                 o_write_offset, o_write_byte, o_frame_length
//
// Every accepted input word yields exactly one result word, registered and valid in the cycle after acceptance.
// A new word can be taken in every unstalled cycle: the frame state and buffer status table
// update at the same edge that loads the result register, so the next word sees the new state.
// o_in_stall rises only while a result is held and the output side stalls.
// Reset (i_rst_n low, synchronous) marks all buffers free, leaves the frame state idle and
// empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module flag_delimited_frame_receiver (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_command,
    input  wire  [7:0]  i_data_byte,
    input  wire  [1:0]  i_release_index,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_event_res,
    output logic        o_write_enable,
    output logic [1:0]  o_buffer_index,
    output logic [10:0] o_write_offset,
    output logic [7:0]  o_write_byte,
    output logic [11:0] o_frame_length
);

    logic                        accept;
    logic [fdfr_pkg::IDX_W-1:0]  cur_buf;
    fdfr_pkg::t_stat_wr          stat_wr;
    fdfr_pkg::t_stat_view        stat_view;
    fdfr_pkg::t_result           next_result;
    fdfr_pkg::t_result           held_result;

    // The result register can take a new word when it is empty or is being drained
    // this cycle; otherwise the input side waits.
    assign o_in_stall = o_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Per-buffer status and the lowest-free-buffer search.
    fdfr_status u_status (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (cur_buf),
        .i_wr     (stat_wr),
        .o_view   (stat_view)
    );

    // Frame delimiting, byte placement and event decode.
    fdfr_frame u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .i_release_index (i_release_index),
        .i_view          (stat_view),
        .o_cur_buf       (cur_buf),
        .o_wr            (stat_wr),
        .o_result        (next_result)
    );

    // Output register that parts the input side from the output side.
    fdfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (next_result),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_result    (held_result)
    );

    assign o_event_res    = held_result.ev;
    assign o_write_enable = held_result.we;
    assign o_buffer_index = held_result.idx;
    assign o_write_offset = held_result.off;
    assign o_write_byte   = held_result.wr_byte;
    assign o_frame_length = held_result.len;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for flag_delimited_frame_receiver.
// Depends on fdfr_pkg and the RTL of the block; it holds its own frame scoreboard class.
// Directed frames and random traffic; every result word is checked.
`timescale 1ns / 1ps

module tb;
    import fdfr_pkg::*;

    localparam int IDLE_PCT     = 22;    // chance in percent that a side idles in a cycle
    localparam int QUIET_FROM   = 600;   // no idling on either side while the accepted word
    localparam int QUIET_TO     = 1100;  // count lies in this range
    localparam int PRESSURE_AT  = 300;   // the receiver holds off once, after this many words
    localparam int HOLD_CYCLES  = 120;
    localparam int RANDOM_WORDS = 1400;
    localparam int TAIL_CYCLES  = 8;

    // The frame scoreboard mirrors the buffer pool and the framing state of the block.
    // Each accepted input word produces exactly one expected result word.
    class frame_scoreboard;
        t_buf_state buf_state [NUM_BUFFERS];
        bit                 open_frame;
        logic [IDX_W-1:0]   open_buf;
        logic [COUNT_W-1:0] frame_bytes;
        t_result            due_results [$];
        int                 errors;
        int                 results_seen;

        function new();
            foreach (buf_state[i]) buf_state[i] = ST_FREE;
            open_frame   = 1'b0;
            open_buf     = '0;
            frame_bytes  = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        // A frame counts as full once its buffer is marked full or its count has
        // reached the buffer size, even if a release has since cleared the status.
        function bit frame_full();
            return buf_state[open_buf] == ST_FULL || frame_bytes >= BUFFER_BYTES;
        endfunction

        function void bump_count();
            if (frame_bytes < BUFFER_BYTES) frame_bytes++;
            if (frame_bytes >= BUFFER_BYTES) buf_state[open_buf] = ST_FULL;
        endfunction

        function void take_word(t_command cmd, logic [7:0] data, logic [IDX_W-1:0] rel);
            t_result r;
            int      found;
            r = '0;
            if (cmd == CMD_RELEASE) begin
                if (rel < NUM_BUFFERS) buf_state[rel] = ST_FREE;
            end else if (!open_frame) begin
                if (data == FLAG_BYTE) begin
                    found = -1;
                    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
                        if (buf_state[i] == ST_FREE) found = i;
                    end
                    if (found < 0) begin
                        r.ev = EV_NO_BUFFER;
                    end else begin
                        open_buf           = found[IDX_W-1:0];
                        buf_state[open_buf] = ST_RECEIVING;
                        frame_bytes        = '0;
                        open_frame         = 1'b1;
                        r.ev      = EV_STORED;
                        r.we      = 1'b1;
                        r.idx     = open_buf;
                        r.wr_byte = data;
                        bump_count();
                    end
                end
            end else if (data == FLAG_BYTE) begin
                // A second flag right after the opening one is swallowed.
                if (frame_bytes != 1) begin
                    if (!frame_full()) begin
                        buf_state[open_buf] = ST_READY;
                        r.ev      = EV_READY;
                        r.we      = 1'b1;
                        r.idx     = open_buf;
                        r.off     = frame_bytes[OFF_W-1:0];
                        r.wr_byte = data;
                        r.len     = frame_bytes + 1'b1;
                    end else begin
                        buf_state[open_buf] = ST_FREE;
                        r.ev  = EV_DROPPED;
                        r.idx = open_buf;
                    end
                    open_frame  = 1'b0;
                    frame_bytes = '0;
                end
            end else begin
                if (!frame_full()) begin
                    r.ev      = EV_STORED;
                    r.we      = 1'b1;
                    r.idx     = open_buf;
                    r.off     = frame_bytes[OFF_W-1:0];
                    r.wr_byte = data;
                end
                bump_count();
            end
            due_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            results_seen++;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d arrived with nothing outstanding", results_seen);
                return;
            end
            exp = due_results.pop_front();
            if (got.ev !== exp.ev || got.we !== exp.we || got.idx !== exp.idx ||
                got.off !== exp.off || got.wr_byte !== exp.wr_byte || got.len !== exp.len) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result %0d: expected ev=%0d we=%0d idx=%0d off=%0d ",
                              "byte=%02h len=%0d, got ev=%0d we=%0d idx=%0d off=%0d ",
                              "byte=%02h len=%0d"}, results_seen,
                             exp.ev, exp.we, exp.idx, exp.off, exp.wr_byte, exp.len,
                             got.ev, got.we, got.idx, got.off, got.wr_byte, got.len);
            end
        endfunction

        function void check_drained();
            if (due_results.size() != 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: %0d result words never arrived", due_results.size());
            end
        endfunction

        // Lowest buffer holding a finished frame, or -1 when there is none.
        function int ready_buffer();
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                if (buf_state[i] == ST_READY) return i;
            end
            return -1;
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic        i_command       = 1'b0;
    logic [7:0]  i_data_byte     = 8'h00;
    logic [1:0]  i_release_index = 2'd0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [2:0]  o_event_res;
    logic        o_write_enable;
    logic [1:0]  o_buffer_index;
    logic [10:0] o_write_offset;
    logic [7:0]  o_write_byte;
    logic [11:0] o_frame_length;

    frame_scoreboard sb;
    int              words_in = 0;   // accepted input words, bumped at the rising edge
    bit              out_hold = 1'b0;

    flag_delimited_frame_receiver u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .i_release_index (i_release_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_write_enable  (o_write_enable),
        .o_buffer_index  (o_buffer_index),
        .o_write_offset  (o_write_offset),
        .o_write_byte    (o_write_byte),
        .o_frame_length  (o_frame_length)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Random idling is switched off for one long stretch of the run. The window is keyed
    // on the accepted word count, which only changes at the rising edge.
    function bit idling_allowed();
        return !(words_in >= QUIET_FROM && words_in < QUIET_TO);
    endfunction

    // Receiver side: stalls at random, or solidly while the hold-off below is active.
    always @(negedge i_clk) begin
        if (out_hold) begin
            i_out_stall <= 1'b1;
        end else if (i_rst_n && idling_allowed() && $urandom_range(0, 99) < IDLE_PCT) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // One long hold-off on the output side while the sender keeps offering words, so the
    // result register fills and the block has to stall its input.
    initial begin
        wait (words_in >= PRESSURE_AT);
        @(posedge i_clk);
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold = 1'b0;
    end

    // Every result word taken by the receiver goes to the scoreboard. Outputs are sampled
    // at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin : watch_results
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.ev      = t_event'(o_event_res);
            got.we      = o_write_enable;
            got.idx     = o_buffer_index;
            got.off     = o_write_offset;
            got.wr_byte = o_write_byte;
            got.len     = o_frame_length;
            sb.check_result(got);
        end
    end

    // Offers one word starting at a falling edge, holds it until the block takes it, and
    // returns at the next falling edge. Idle cycles, if any, come before the word.
    task automatic send_word(input t_command cmd, input logic [7:0] data,
                             input logic [1:0] rel);
        while (idling_allowed() && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_data_byte     <= data;
        i_release_index <= rel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_word(cmd, data, rel);
        words_in++;
        @(negedge i_clk);
    endtask

    // The unused field of each word carries random bits so that every input bit toggles.
    task automatic send_byte(input logic [7:0] data);
        send_word(CMD_BYTE, data, 2'($urandom_range(0, 3)));
    endtask

    task automatic send_release(input logic [1:0] idx);
        send_word(CMD_RELEASE, 8'($urandom_range(0, 255)), idx);
    endtask

    // Frame payload never contains a flag, so the frame stays open for all n bytes.
    task automatic send_body(input int n);
        logic [7:0] data;
        repeat (n) begin
            data = 8'($urandom_range(0, 255));
            if (data == FLAG_BYTE) data = 8'h7d;
            send_byte(data);
        end
    endtask

    // Timeout guard: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("flag_delimited_frame_receiver: mismatch");
        $finish;
    end

    initial begin
        int pick;
        int body;
        int ready;
        int stop_at;

        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Bytes outside a frame are ignored.
        send_byte(8'h00);
        send_byte(8'hff);
        // Frame in buffer 0 with a swallowed second flag after the opening one.
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h55);
        send_byte(FLAG_BYTE);
        // Buffer 1: two swallowed flags in a row, then a one-byte frame.
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(8'haa);
        send_byte(FLAG_BYTE);
        // Buffers 2 and 3 fill the pool.
        send_byte(FLAG_BYTE);
        send_byte(8'h81);
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(8'h01);
        send_byte(FLAG_BYTE);
        // No buffer free: the flag is refused, and the next one tries again.
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        // Free buffer 2, claim it, then release it while the frame is still being received.
        send_release(2'd2);
        send_byte(FLAG_BYTE);
        send_release(2'd2);
        send_byte(8'h34);
        send_byte(FLAG_BYTE);
        for (int i = 0; i < NUM_BUFFERS; i++) send_release(i[1:0]);

        // Random traffic: mostly well-formed frames of short random payload, each usually
        // followed by the consumer releasing a finished buffer; the rest is stray releases
        // and line noise that may open frames at odd moments.
        stop_at = words_in + RANDOM_WORDS;
        while (words_in < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_byte(FLAG_BYTE);
                if ($urandom_range(0, 9) == 0) send_byte(FLAG_BYTE);
                if ($urandom_range(0, 9) == 0) body = $urandom_range(0, 60);
                else body = $urandom_range(0, 10);
                send_body(body);
                if ($urandom_range(0, 19) == 0) send_release(2'($urandom_range(0, 3)));
                send_byte(FLAG_BYTE);
                if ($urandom_range(0, 3) != 0) begin
                    ready = sb.ready_buffer();
                    if (ready >= 0) send_release(ready[1:0]);
                    else send_release(2'($urandom_range(0, 3)));
                end
            end else if (pick < 80) begin
                send_release(2'($urandom_range(0, 3)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 4) == 0) send_byte(FLAG_BYTE);
                    else send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        i_in_valid <= 1'b0;

        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("flag_delimited_frame_receiver: match");
        end else begin
            $display("flag_delimited_frame_receiver: mismatch");
        end
        $finish;
    end

endmodule
